// ===== rtl/core/ptrain_pkg.sv =====
// Shared types and constants for the perceptron training block.
package ptrain_pkg;

  // Fixed field widths of the item channels
  localparam int FUNC_W = 2;
  localparam int FEAT_W = 8;
  localparam int RATE_W = 16;
  localparam int IDX_W  = 4;
  localparam int W_W    = 20;
  localparam int ERR_W  = 2;
  localparam int ACT_W  = 24;

  // Fraction bits of the rate field
  localparam int RATE_FRAC = 16;

  // Weight saturation bounds
  localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

  // Item function codes; the unused code acts as classify
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TRAIN    = 2'd0,
    FUNC_LOAD     = 2'd1,
    FUNC_CLASSIFY = 2'd2,
    FUNC_SPARE    = 2'd3
  } func_t;

  typedef logic signed [W_W-1:0]   weight_t;
  typedef logic signed [ACT_W-1:0] act_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // Error codes
  localparam err_t ERR_NONE = 2'sd0;
  localparam err_t ERR_POS  = 2'sd1;
  localparam err_t ERR_NEG  = -2'sd1;

endpackage

// ===== rtl/core/ptrain_if.sv =====
// Valid/ready channel interfaces for the train items and the results.
interface ptrain_in_if
  import ptrain_pkg::*;
();
  logic          valid;
  logic          ready;
  func_t         func;
  logic [FEAT_W-1:0] features;
  logic          target;
  logic [RATE_W-1:0] rate;
  logic [IDX_W-1:0]  index;
  weight_t       value;

  modport source (output valid, func, features, target, rate, index, value, input ready);
  modport sink   (input valid, func, features, target, rate, index, value, output ready);
endinterface

interface ptrain_out_if
  import ptrain_pkg::*;
();
  logic valid;
  logic ready;
  logic predicted;
  err_t error;
  act_t activation;

  modport source (output valid, predicted, error, activation, input ready);
  modport sink   (input valid, predicted, error, activation, output ready);
endinterface

// ===== rtl/core/perceptron_train_step.sv =====
// Single-layer perceptron, online training, one item per cycle unless stalled.
//
// Channels: in_ch takes train, load and classify items; out_ch returns one
// result (predicted, error, activation) per item, in order. A transfer
// happens at a rising clk edge with valid and ready both high.
// Path: an accepted item sits in the input register while the masked add
// tree and weight update run; once the result register is free, an edge
// loads its result into the output register and out valid rises.
// Throughput: one item per cycle unless stalled. The weights and bias are
// written at the edge that moves an item from the input register to the
// output register, so the following item already sees the updated values.
// Reset (rst_n low, synchronous): both registers empty, all weights and
// the bias cleared to zero.
// Stall: while out ready is low the result holds; the input register still
// accepts one more item, then in ready drops until the result is taken.
module perceptron_train_step
  import ptrain_pkg::*;
#(
  parameter int NUM_INPUTS = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ptrain_in_if.sink    in_ch,
  ptrain_out_if.source out_ch
);

  // Only the first FEAT_W weights can ever be selected by a feature bit
  localparam int NUM_ACT = (NUM_INPUTS < FEAT_W) ? NUM_INPUTS : FEAT_W;
  localparam int SH_L    = (FRAC_BITS > RATE_FRAC) ? FRAC_BITS - RATE_FRAC : 0;
  localparam int SH_R    = (FRAC_BITS < RATE_FRAC) ? RATE_FRAC - FRAC_BITS : 0;
  localparam int DELTA_W = RATE_W + SH_L;
  localparam int SUM_W   = ((DELTA_W > W_W) ? DELTA_W : W_W) + 2;

  // Input register
  logic              s1_valid_r;
  func_t             s1_func_r;
  logic [FEAT_W-1:0] s1_features_r;
  logic              s1_target_r;
  logic [RATE_W-1:0] s1_rate_r;
  logic [IDX_W-1:0]  s1_index_r;
  weight_t           s1_value_r;

  // Result register
  logic out_valid_r;
  logic out_pred_r;
  err_t out_err_r;
  act_t out_act_r;

  // Weight state
  weight_t weights_r [NUM_INPUTS];
  weight_t weights_nxt [NUM_INPUTS];
  weight_t bias_r;
  weight_t bias_nxt;

  logic              s1_adv;
  logic              in_fire;
  act_t              act;
  logic              pred;
  err_t              err;
  logic              do_update;
  logic              step_neg;
  logic [DELTA_W-1:0] delta;

  // Add or subtract the step, clamped to the weight range
  function automatic weight_t sat_step(weight_t w, logic [DELTA_W-1:0] d, logic neg);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] dx;
    dx  = $signed({{(SUM_W-DELTA_W){1'b0}}, d});
    sum = neg ? (SUM_W'(w) - dx) : (SUM_W'(w) + dx);
    if (sum > SUM_W'(W_MAX)) begin
      return W_MAX;
    end else if (sum < SUM_W'(W_MIN)) begin
      return W_MIN;
    end
    return sum[W_W-1:0];
  endfunction

  // Handshake: the input register moves on whenever the result register frees up
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Activation: bias plus the weights whose feature bit is set
  always_comb begin
    act = ACT_W'(bias_r);
    for (int i = 0; i < NUM_ACT; i++) begin
      if (s1_features_r[i]) begin
        act = act + ACT_W'(weights_r[i]);
      end
    end
  end

  assign pred = !act[ACT_W-1] && (act != '0);

  // Error and step size
  always_comb begin
    if (s1_func_r == FUNC_TRAIN) begin
      err = (s1_target_r == pred) ? ERR_NONE : (s1_target_r ? ERR_POS : ERR_NEG);
    end else begin
      err = ERR_NONE;
    end
  end

  assign do_update = s1_adv && (s1_func_r == FUNC_TRAIN) && (s1_target_r != pred);
  assign step_neg  = !s1_target_r;
  assign delta     = (DELTA_W'(s1_rate_r) << SH_L) >> SH_R;

  // Next weights: train update on active slots, or a load of one slot
  always_comb begin
    for (int i = 0; i < NUM_INPUTS; i++) begin
      weights_nxt[i] = weights_r[i];
      if (do_update && (i < NUM_ACT) && s1_features_r[i % FEAT_W]) begin
        weights_nxt[i] = sat_step(weights_r[i], delta, step_neg);
      end else if (s1_adv && (s1_func_r == FUNC_LOAD) && (32'(s1_index_r) == i)) begin
        weights_nxt[i] = s1_value_r;
      end
    end
    bias_nxt = bias_r;
    if (do_update) begin
      bias_nxt = sat_step(bias_r, delta, step_neg);
    end else if (s1_adv && (s1_func_r == FUNC_LOAD) && (32'(s1_index_r) == NUM_INPUTS)) begin
      bias_nxt = s1_value_r;
    end
  end

  // Weight state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        weights_r[i] <= '0;
      end
      bias_r <= '0;
    end else begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        weights_r[i] <= weights_nxt[i];
      end
      bias_r <= bias_nxt;
    end
  end

  // Input register: capture on transfer, drop when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r     <= in_ch.func;
      s1_features_r <= in_ch.features;
      s1_target_r   <= in_ch.target;
      s1_rate_r     <= in_ch.rate;
      s1_index_r    <= in_ch.index;
      s1_value_r    <= in_ch.value;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pred_r <= pred;
      out_err_r  <= err;
      out_act_r  <= act;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.predicted  = out_pred_r;
  assign out_ch.error      = out_err_r;
  assign out_ch.activation = out_act_r;

endmodule

// ===== rtl/core/ptrain_checker.sv =====
// Port-level checks, bound to the perceptron_train_step module.
module ptrain_checker
  import ptrain_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_predicted,
  input err_t out_error,
  input act_t out_activation
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_activation)
      && $stable(out_error) && $stable(out_predicted))
    else $error("result changed while stalled");

  // Predicted follows the sign of the activation
  a_pred_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_predicted == (!out_activation[ACT_W-1] && out_activation != '0))
    else $error("predicted does not match activation");

  // Error never takes the unused code
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error != -2'sd2)
    else $error("error out of range");

  // A nonzero error always points away from the prediction
  a_err_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error != ERR_NONE |-> (out_error == ERR_POS) == !out_predicted)
    else $error("error sign disagrees with prediction");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind perceptron_train_step ptrain_checker u_ptrain_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_predicted  (out_ch.predicted),
  .out_error      (out_ch.error),
  .out_activation (out_ch.activation)
);

// ===== dv/perceptron_train_step_test.sv =====
// Self-checking testbench for perceptron_train_step: queued driver, monitor, inline predictor.
module perceptron_train_step_test;
  import ptrain_pkg::*;

  localparam int N_WEIGHTS    = 8;
  localparam int STEP_FRAC    = 16;
  localparam int N_PHASES     = 4;
  localparam int PHASE_ITEMS  = 412;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    func_t             func;
    logic [FEAT_W-1:0] features;
    logic              target;
    logic [RATE_W-1:0] rate;
    logic [IDX_W-1:0]  index;
    weight_t           value;
    bit                drain_first;
    int                phase;
  } train_item_t;

  typedef struct {
    logic predicted;
    err_t error;
    act_t activation;
  } step_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ptrain_in_if  in_ch();
  ptrain_out_if out_ch();

  perceptron_train_step #(
    .NUM_INPUTS(N_WEIGHTS),
    .FRAC_BITS (STEP_FRAC)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Pacing per phase: none, sender idle, receiver stall, both
  int send_idle_pct[N_PHASES]  = '{0, 64, 0, 18};
  int recv_stall_pct[N_PHASES] = '{0, 0, 64, 18};

  // Predictor state
  weight_t model_w[N_WEIGHTS];
  weight_t model_bias;

  train_item_t  stim_items[$];
  train_item_t  cur_item;
  step_result_t pending_results[$];

  int items_sent    = 0;
  int recv_count    = 0;
  int fail_count    = 0;
  int cycle_count   = 0;
  int cur_phase     = 0;
  int n_train       = 0;
  int n_load        = 0;
  int n_classify    = 0;
  int n_corrections = 0;

  always #5 clk = ~clk;

  function automatic weight_t clamp_weight(longint v);
    if (v > longint'(W_MAX)) return W_MAX;
    if (v < longint'(W_MIN)) return W_MIN;
    return weight_t'(v);
  endfunction

  // Threshold the masked sum, then apply the learning rule or the load
  function automatic step_result_t classify_and_learn(train_item_t it);
    step_result_t r;
    longint acc;
    longint step;
    acc = longint'(model_bias);
    for (int i = 0; i < N_WEIGHTS; i++)
      if (it.features[i]) acc += longint'(model_w[i]);
    r.predicted  = (acc > 0);
    r.error      = ERR_NONE;
    // nine 20-bit terms always fit the 24-bit activation
    r.activation = act_t'(acc);
    case (it.func)
      FUNC_TRAIN: begin
        if (it.target && !r.predicted) r.error = ERR_POS;
        else if (!it.target && r.predicted) r.error = ERR_NEG;
        step = (longint'(it.rate) << STEP_FRAC) >> RATE_FRAC;
        if (r.error == ERR_NEG) step = -step;
        if (r.error != ERR_NONE) begin
          for (int i = 0; i < N_WEIGHTS; i++)
            if (it.features[i]) model_w[i] = clamp_weight(longint'(model_w[i]) + step);
          model_bias = clamp_weight(longint'(model_bias) + step);
        end
      end
      FUNC_LOAD: begin
        if (it.index < N_WEIGHTS) model_w[it.index] = it.value;
        else if (it.index == N_WEIGHTS) model_bias = it.value;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(func_t f, logic [FEAT_W-1:0] feat, logic tgt,
                          logic [RATE_W-1:0] rt, logic [IDX_W-1:0] idx,
                          weight_t val, bit drain);
    train_item_t it;
    it.func        = f;
    it.features    = feat;
    it.target      = tgt;
    it.rate        = rt;
    it.index       = idx;
    it.value       = val;
    it.drain_first = drain;
    it.phase       = 0;
    stim_items.push_back(it);
  endtask

  // Driver: present queued items, pace by phase, hold off for a full drain when asked
  always @(posedge clk) begin
    step_result_t exp_res;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // Predict on each input transfer
      if (in_ch.valid && in_ch.ready) begin
        exp_res = classify_and_learn(cur_item);
        pending_results.push_back(exp_res);
        items_sent++;
        case (cur_item.func)
          FUNC_TRAIN: begin
            n_train++;
            if (exp_res.error != ERR_NONE) n_corrections++;
          end
          FUNC_LOAD: n_load++;
          default:   n_classify++;
        endcase
      end
      // Advance to the next item once the bus is free
      if (!in_ch.valid || in_ch.ready) begin
        if (stim_items.size() > 0 &&
            !(stim_items[0].drain_first && recv_count != items_sent) &&
            $urandom_range(99) >= send_idle_pct[stim_items[0].phase]) begin
          cur_item = stim_items.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.func     <= cur_item.func;
          in_ch.features <= cur_item.features;
          in_ch.target   <= cur_item.target;
          in_ch.rate     <= cur_item.rate;
          in_ch.index    <= cur_item.index;
          in_ch.value    <= cur_item.value;
          cur_phase      <= cur_item.phase;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    step_result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        recv_count <= recv_count + 1;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: predicted %0b error %0d activation %0d",
                 out_ch.predicted, out_ch.error, out_ch.activation);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_ch.predicted !== exp_res.predicted) begin
            $error("predicted: expected %0b, got %0b", exp_res.predicted, out_ch.predicted);
            fail_count++;
          end
          if (out_ch.error !== exp_res.error) begin
            $error("error: expected %0d, got %0d", exp_res.error, out_ch.error);
            fail_count++;
          end
          if (out_ch.activation !== exp_res.activation) begin
            $error("activation: expected %0d, got %0d", exp_res.activation,
                   out_ch.activation);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    train_item_t it;
    int roll;
    foreach (model_w[i]) model_w[i] = '0;
    model_bias     = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_TRAIN;
    in_ch.features = '0;
    in_ch.target   = 1'b0;
    in_ch.rate     = '0;
    in_ch.index    = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b1;

    // Directed: zero state, both error signs, zero error, spare code, ignored slots
    add_item(FUNC_CLASSIFY, 8'hFF, 1'b0, 16'h0000, '0, '0, 1'b0);
    add_item(FUNC_TRAIN,    8'h00, 1'b0, 16'hFFFF, '0, '0, 1'b0);
    add_item(FUNC_TRAIN,    8'hFF, 1'b1, 16'hFFFF, '0, '0, 1'b0);
    add_item(FUNC_TRAIN,    8'hAA, 1'b0, 16'h0001, '0, '0, 1'b0);
    add_item(FUNC_SPARE,    8'h55, 1'b1, 16'h1234, 4'd3, 20'sd12345, 1'b0);
    add_item(FUNC_LOAD,     8'h00, 1'b0, 16'h0000, 4'd9, 20'sd12345, 1'b0);
    add_item(FUNC_LOAD,     8'h00, 1'b0, 16'h0000, 4'hF, W_MIN, 1'b0);
    // Every slot to the top of the range, then the largest activation
    for (int k = 0; k <= N_WEIGHTS; k++)
      add_item(FUNC_LOAD, 8'h00, 1'b0, 16'h0000, IDX_W'(k), W_MAX, 1'b0);
    add_item(FUNC_CLASSIFY, 8'hFF, 1'b0, 16'h0000, '0, '0, 1'b1);
    // Wrong prediction with a zero rate leaves the weights alone
    add_item(FUNC_TRAIN,    8'hFF, 1'b0, 16'h0000, '0, '0, 1'b0);
    // Positive saturation of weight 1, negative saturation of weight 0
    add_item(FUNC_LOAD,     8'h00, 1'b0, 16'h0000, 4'd0, W_MIN, 1'b0);
    add_item(FUNC_LOAD,     8'h00, 1'b0, 16'h0000, IDX_W'(N_WEIGHTS), W_MIN, 1'b0);
    add_item(FUNC_TRAIN,    8'h02, 1'b1, 16'hFFFF, '0, '0, 1'b0);
    add_item(FUNC_TRAIN,    8'h07, 1'b0, 16'hFFFF, '0, '0, 1'b0);
    add_item(FUNC_CLASSIFY, 8'hFF, 1'b0, 16'h0000, '0, '0, 1'b0);

    // Random: mostly training with random weight loads and some classify traffic
    for (int p = 0; p < N_PHASES; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.features = FEAT_W'($urandom);
        it.target   = 1'($urandom);
        it.index    = IDX_W'($urandom_range(N_WEIGHTS));
        if ($urandom_range(3) == 0) it.rate = RATE_W'($urandom);
        else it.rate = RATE_W'($urandom_range(4095));
        if ($urandom_range(1)) it.value = weight_t'($urandom);
        else it.value = weight_t'(int'($urandom_range(262143)) - 131072);
        roll = int'($urandom_range(99));
        if (roll < 78) begin
          it.func = FUNC_TRAIN;
        end else if (roll < 88) begin
          it.func = FUNC_LOAD;
        end else if (roll < 90) begin
          it.func  = FUNC_LOAD;
          it.index = IDX_W'($urandom_range(15, N_WEIGHTS + 1));
        end else if (roll < 97) begin
          it.func = FUNC_CLASSIFY;
        end else begin
          it.func = FUNC_SPARE;
        end
        it.drain_first = ($urandom_range(199) == 0) || (n == PHASE_ITEMS / 2);
        it.phase       = p;
        stim_items.push_back(it);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sample mid-cycle so the drain test sees settled values
    while (stim_items.size() > 0 || in_ch.valid || recv_count != items_sent)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end

    $display("Ran %0d items: %0d train (%0d corrected weights), %0d load, %0d classify",
             items_sent, n_train, n_corrections, n_load, n_classify);
    $display("Checked %0d results across four pacing phases, %0d mismatches",
             recv_count, fail_count);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ptrain_pkg.sv
rtl/core/ptrain_if.sv
rtl/core/perceptron_train_step.sv
rtl/core/ptrain_checker.sv
dv/perceptron_train_step_test.sv
